@@ rtl/core/mandelbrot_escape_time_macros.svh @@
// Assertion macros for the Mandelbrot escape-time engine.
// Taken in by the top level; no other dependencies.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/met_pkg.sv @@
// Shared constants for the Mandelbrot escape-time engine: field widths,
// register indexes and register reset values. No dependencies.
package met_pkg;

   localparam int REG_FRAC      = 28;   // fraction bits of the Q4.28 registers
   localparam int DEF_FRAC_BITS = 28;
   localparam int MUL_W         = 32;   // operand width of the shared multiplier

   localparam int COL_W       = 14;
   localparam int CNT_W       = 16;
   localparam int ADDR_W      = 28;
   localparam int STEP_W      = 31;
   localparam int ORG_W       = 32;
   localparam int DIM_W       = 15;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int RAW_W       = 45;     // pixel index times step size

   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_REAL     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_IMAG     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITERATION_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_COLS      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_ROWS      = 3'd5;

   localparam logic [STEP_W-1:0] RST_STEP_SIZE       = 31'd1048576;
   localparam logic [ORG_W-1:0]  RST_ORIGIN_REAL     = 32'hE000_0000;  // -2.0
   localparam logic [ORG_W-1:0]  RST_ORIGIN_IMAG     = 32'hF000_0000;  // -1.0
   localparam logic [CNT_W-1:0]  RST_ITERATION_LIMIT = 16'd256;
   localparam logic [DIM_W-1:0]  RST_IMAGE_COLS      = 15'd1024;
   localparam logic [DIM_W-1:0]  RST_IMAGE_ROWS      = 15'd1024;

endpackage

@@ rtl/core/mandelbrot_escape_time.sv @@
// Mandelbrot escape-time engine: a pixel request in, its iteration count and
// linear address out. A request outside the configured image is taken and
// gives no response. For a pixel inside, the work grows with its iteration
// count n and with K = ceil((FRAC_BITS+4)/32) (K = 1 at the default format).
// Every product - pixel coordinates times step, the address, and the two
// squares and the cross product of each iteration - goes through one 32x32
// multiplier, one partial product per cycle; that multiplier sets the rate.
// A new request is taken only when the engine is idle; a finished response
// may still be waiting in the output register. Depends on met_pkg and
// mandelbrot_escape_time_macros.svh.
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time
   import met_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COL_W-1:0]       req_pixel_col,
   input  logic [COL_W-1:0]       req_pixel_row,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CNT_W-1:0]       rsp_iteration_count,
   output logic [ADDR_W-1:0]      rsp_pixel_address,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int W       = FRAC_BITS + 4;              // width of z and c
   localparam int K       = (W + MUL_W - 1) / MUL_W;    // chunks per operand
   localparam int KW      = K * MUL_W;
   localparam int AW      = 2 * KW;                     // product accumulators
   localparam int IAW     = (K > 1) ? $clog2(K) : 1;
   localparam int SHW     = IAW + 1;
   localparam int LSH     = (FRAC_BITS >= REG_FRAC) ? FRAC_BITS - REG_FRAC : 0;
   localparam int RSH     = (FRAC_BITS < REG_FRAC) ? REG_FRAC - FRAC_BITS : 0;
   localparam int ESC_BIT = 2 * FRAC_BITS + 2;          // |z|^2 >= 4

   localparam logic [IAW-1:0]        CHUNK_LAST = IAW'(K - 1);
   localparam logic [AW:0]           ESC_THR    = {{AW{1'b0}}, 1'b1} << ESC_BIT;
   localparam logic signed [AW+1:0]  ZMAX       = {{(AW + 3 - W){1'b0}}, {(W - 1){1'b1}}};
   localparam logic signed [AW+1:0]  ZMIN       = ~ZMAX;
   localparam logic signed [RAW_W+1:0] C32_MAX  = 47'sd2147483647;
   localparam logic signed [RAW_W+1:0] C32_MIN  = -47'sd2147483648;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SETUP  = 4'd1;
   localparam logic [3:0] ST_SDRAIN = 4'd2;
   localparam logic [3:0] ST_CBUILD = 4'd3;
   localparam logic [3:0] ST_UPDATE = 4'd4;
   localparam logic [3:0] ST_MUL    = 4'd5;
   localparam logic [3:0] ST_MDRAIN = 4'd6;
   localparam logic [3:0] ST_CHECK  = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   localparam logic [2:0] TGT_RR   = 3'd0;
   localparam logic [2:0] TGT_II   = 3'd1;
   localparam logic [2:0] TGT_P    = 3'd2;
   localparam logic [2:0] TGT_CR   = 3'd3;
   localparam logic [2:0] TGT_CI   = 3'd4;
   localparam logic [2:0] TGT_ADDR = 3'd5;

   // configuration
   logic [STEP_W-1:0]       step_ff;
   logic signed [ORG_W-1:0] org_re_ff;
   logic signed [ORG_W-1:0] org_im_ff;
   logic [CNT_W-1:0]        limit_ff;
   logic [DIM_W-1:0]        cols_ff;
   logic [DIM_W-1:0]        rows_ff;

   // sequencer
   logic [3:0]     state_ff, state_in;
   logic [2:0]     tgt_ff, tgt_in;
   logic [IAW-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // request and datapath
   logic [COL_W-1:0]        col_ff, row_ff;
   logic [63:0]             prod_ff;
   logic                    pvld_ff;
   logic [2:0]              ptgt_ff;
   logic [SHW-1:0]          psh_ff;
   logic [AW-1:0]           rr_ff, ii_ff, pm_ff;
   logic signed [AW:0]      d_ff, ps_ff;
   logic signed [W-1:0]     zr_ff, zi_ff, cr_ff, ci_ff;
   logic [RAW_W-1:0]        craw_ff, ciraw_ff;
   logic [ADDR_W-1:0]       addr_ff;

   // response register
   logic                rsp_valid_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;

   logic                accept, in_image, issue, rsp_load, escape, at_limit;
   logic [CNT_W-1:0]    lim_eff;
   logic [W-1:0]        mag_r, mag_i;
   logic [KW-1:0]       opa_w, opb_w;
   logic [MUL_W-1:0]    op_a, op_b;
   logic [AW-1:0]       pp_shift;
   logic [AW:0]         sq_sum;
   logic signed [AW:0]  d_in, ps_in, re_w, im_w;
   logic signed [AW+1:0] sum_r, sum_i;
   logic signed [W-1:0] zr_in, zi_in, cr_in, ci_in;

   // c = idx*step + origin, saturated to Q4.28, then moved to FRAC_BITS
   function automatic logic signed [W-1:0] make_c(input logic [RAW_W-1:0] raw,
                                                  input logic signed [ORG_W-1:0] org);
      logic signed [RAW_W+1:0] v;
      logic signed [ORG_W-1:0] s32;
      v = $signed({2'b00, raw}) + (RAW_W + 2)'(org);
      if (v > C32_MAX) begin
         s32 = C32_MAX[ORG_W-1:0];
      end else if (v < C32_MIN) begin
         s32 = C32_MIN[ORG_W-1:0];
      end else begin
         s32 = v[ORG_W-1:0];
      end
      if (FRAC_BITS >= REG_FRAC) begin
         make_c = W'(s32) <<< LSH;
      end else begin
         make_c = W'(s32 >>> RSH);
      end
   endfunction

   function automatic logic signed [W-1:0] sat_z(input logic signed [AW+1:0] v);
      if (v > ZMAX) begin
         sat_z = ZMAX[W-1:0];
      end else if (v < ZMIN) begin
         sat_z = ZMIN[W-1:0];
      end else begin
         sat_z = v[W-1:0];
      end
   endfunction

   assign req_stall           = (state_ff != ST_IDLE);
   assign accept              = req_valid && !req_stall;
   assign in_image            = ({1'b0, req_pixel_col} < cols_ff) &&
                                ({1'b0, req_pixel_row} < rows_ff);
   assign issue               = (state_ff == ST_SETUP) || (state_ff == ST_MUL);
   assign rsp_load            = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign lim_eff             = (limit_ff == '0) ? CNT_W'(1) : limit_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_pixel_address   = rsp_addr_ff;

   // ---------------------------------------------------------------- multiplier
   assign mag_r = zr_ff[W-1] ? W'(-zr_ff) : W'(zr_ff);
   assign mag_i = zi_ff[W-1] ? W'(-zi_ff) : W'(zi_ff);

   always_comb begin
      unique case (tgt_ff)
         TGT_RR: begin
            opa_w = KW'(mag_r);
            opb_w = KW'(mag_r);
         end
         TGT_II: begin
            opa_w = KW'(mag_i);
            opb_w = KW'(mag_i);
         end
         TGT_P: begin
            opa_w = KW'(mag_r);
            opb_w = KW'(mag_i);
         end
         TGT_CR: begin
            opa_w = KW'(col_ff);
            opb_w = KW'(step_ff);
         end
         TGT_CI: begin
            opa_w = KW'(row_ff);
            opb_w = KW'(step_ff);
         end
         TGT_ADDR: begin
            opa_w = KW'(row_ff);
            opb_w = KW'(cols_ff);
         end
         default: begin
            opa_w = '0;
            opb_w = '0;
         end
      endcase
   end

   assign op_a     = MUL_W'(opa_w >> {ia_ff, 5'd0});
   assign op_b     = MUL_W'(opb_w >> {ib_ff, 5'd0});
   assign pp_shift = AW'(prod_ff) << {psh_ff, 5'd0};

   // ---------------------------------------------------------------- iteration math
   assign sq_sum = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign escape = (sq_sum >= ESC_THR);
   assign at_limit = (count_ff >= lim_eff);
   assign d_in   = $signed({1'b0, rr_ff}) - $signed({1'b0, ii_ff});
   assign ps_in  = (zr_ff[W-1] ^ zi_ff[W-1]) ? -$signed({1'b0, pm_ff})
                                              : $signed({1'b0, pm_ff});
   // arithmetic shifts floor toward minus infinity
   assign re_w   = d_ff >>> FRAC_BITS;
   assign im_w   = ps_ff >>> (FRAC_BITS - 1);
   assign sum_r  = (AW + 2)'(re_w) + (AW + 2)'(cr_ff);
   assign sum_i  = (AW + 2)'(im_w) + (AW + 2)'(ci_ff);
   assign zr_in  = sat_z(sum_r);
   assign zi_in  = sat_z(sum_i);
   assign cr_in  = make_c(craw_ff, org_re_ff);
   assign ci_in  = make_c(ciraw_ff, org_im_ff);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      tgt_in   = tgt_ff;
      ia_in    = ia_ff;
      ib_in    = ib_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_image) begin
               state_in = ST_SETUP;
               tgt_in   = TGT_CR;
               ia_in    = '0;
               ib_in    = '0;
               count_in = '0;
            end
         end
         ST_SETUP: begin
            if (tgt_ff == TGT_ADDR) begin
               state_in = ST_SDRAIN;
            end else begin
               tgt_in = tgt_ff + 3'd1;
            end
         end
         ST_SDRAIN: state_in = ST_CBUILD;
         ST_CBUILD: state_in = ST_UPDATE;
         ST_UPDATE: begin
            state_in = ST_MUL;
            tgt_in   = TGT_RR;
            ia_in    = '0;
            ib_in    = '0;
            count_in = count_ff + CNT_W'(1);
         end
         ST_MUL: begin
            // walk the chunk pairs of one product, then the next product
            if (ib_ff != CHUNK_LAST) begin
               ib_in = ib_ff + IAW'(1);
            end else begin
               ib_in = '0;
               if (ia_ff != CHUNK_LAST) begin
                  ia_in = ia_ff + IAW'(1);
               end else begin
                  ia_in = '0;
                  if (tgt_ff == TGT_P) begin
                     state_in = ST_MDRAIN;
                  end else begin
                     tgt_in = tgt_ff + 3'd1;
                  end
               end
            end
         end
         ST_MDRAIN: state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = (escape || at_limit) ? ST_FINISH : ST_UPDATE;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tgt_ff       <= TGT_RR;
         ia_ff        <= '0;
         ib_ff        <= '0;
         count_ff     <= '0;
         pvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= RST_STEP_SIZE;
         org_re_ff    <= RST_ORIGIN_REAL;
         org_im_ff    <= RST_ORIGIN_IMAG;
         limit_ff     <= RST_ITERATION_LIMIT;
         cols_ff      <= RST_IMAGE_COLS;
         rows_ff      <= RST_IMAGE_ROWS;
      end else begin
         state_ff <= state_in;
         tgt_ff   <= tgt_in;
         ia_ff    <= ia_in;
         ib_ff    <= ib_in;
         count_ff <= count_in;
         pvld_ff  <= issue;
         priority if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_STEP_SIZE:       step_ff   <= csr_wdata[STEP_W-1:0];
               CSR_ORIGIN_REAL:     org_re_ff <= csr_wdata[ORG_W-1:0];
               CSR_ORIGIN_IMAG:     org_im_ff <= csr_wdata[ORG_W-1:0];
               CSR_ITERATION_LIMIT: limit_ff  <= csr_wdata[CNT_W-1:0];
               CSR_IMAGE_COLS:      cols_ff   <= csr_wdata[DIM_W-1:0];
               CSR_IMAGE_ROWS:      rows_ff   <= csr_wdata[DIM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      prod_ff <= 64'(op_a) * 64'(op_b);
      ptgt_ff <= tgt_ff;
      psh_ff  <= SHW'(ia_ff) + SHW'(ib_ff);

      if (accept) begin
         col_ff <= req_pixel_col;
         row_ff <= req_pixel_row;
         d_ff   <= '0;
         ps_ff  <= '0;
      end

      priority if (state_ff == ST_UPDATE) begin
         rr_ff <= '0;
         ii_ff <= '0;
         pm_ff <= '0;
      end else if (pvld_ff) begin
         unique case (ptgt_ff)
            TGT_RR:   rr_ff    <= rr_ff + pp_shift;
            TGT_II:   ii_ff    <= ii_ff + pp_shift;
            TGT_P:    pm_ff    <= pm_ff + pp_shift;
            TGT_CR:   craw_ff  <= prod_ff[RAW_W-1:0];
            TGT_CI:   ciraw_ff <= prod_ff[RAW_W-1:0];
            TGT_ADDR: addr_ff  <= prod_ff[ADDR_W-1:0];
            default: ;
         endcase
      end

      if (state_ff == ST_CBUILD) begin
         cr_ff   <= cr_in;
         ci_ff   <= ci_in;
         addr_ff <= addr_ff + ADDR_W'(col_ff);
      end

      if (state_ff == ST_UPDATE) begin
         zr_ff <= zr_in;
         zi_ff <= zi_in;
      end

      if (state_ff == ST_CHECK) begin
         d_ff  <= d_in;
         ps_ff <= ps_in;
      end

      if (rsp_load) begin
         rsp_count_ff <= count_ff;
         rsp_addr_ff  <= addr_ff;
      end
   end

   // ---------------------------------------------------------------- checks
   `MET_ASSERT_NEXT(a_start_setup, clock, reset, accept && in_image,
      state_ff == ST_SETUP, "in-image request did not start setup")
   `MET_ASSERT_NOW(a_count_range, clock, reset, state_ff == ST_CHECK,
      (count_ff != '0) && (count_ff <= lim_eff), "iteration count out of range")
   `MET_ASSERT_NOW(a_prod_phase, clock, reset, pvld_ff,
      (state_ff == ST_SETUP) || (state_ff == ST_SDRAIN) || (state_ff == ST_MUL) ||
      (state_ff == ST_MDRAIN), "partial product landed outside a multiply phase")
   `MET_ASSERT_NEXT(a_finish_load, clock, reset, rsp_load,
      rsp_valid_ff && (state_ff == ST_IDLE), "response not presented after finish")

endmodule
